// ===== sv/plm_pkg.sv =====
package plm_pkg;

    // Fixed field widths
    localparam int SCALE_W      = 12;
    localparam int HOLD_TICKS_W = 8;
    localparam int HOLD_W       = 9;
    localparam int ZONE_W       = 3;
    localparam int CFG_IDX_W    = 3;

    localparam logic [HOLD_W-1:0] HOLD_MAX = 9'd511;

    // Cube root: the target is scale^3 * level >> (level fraction bits), which
    // always has 3 * SCALE_W + 2 bits whatever the level width.
    localparam int TGT_W      = 3 * SCALE_W + 2;
    localparam int ROOT_STEPS = (TGT_W + 2) / 3;
    localparam int ROOT_W     = ROOT_STEPS;
    localparam int XPAD_W     = 3 * ROOT_STEPS;
    localparam int REM_W      = 2 * ROOT_W + 5;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

    typedef logic [ZONE_W-1:0]    zone_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam zone_t ZONE_OVER  = 3'd0;
    localparam zone_t ZONE_ZERO  = 3'd1;
    localparam zone_t ZONE_THREE = 3'd2;
    localparam zone_t ZONE_SIX   = 3'd3;
    localparam zone_t ZONE_TEN   = 3'd4;

    localparam cfg_idx_t CFG_SCALE      = 3'd0;
    localparam cfg_idx_t CFG_ZERO_DB    = 3'd1;
    localparam cfg_idx_t CFG_THREE_DB   = 3'd2;
    localparam cfg_idx_t CFG_SIX_DB     = 3'd3;
    localparam cfg_idx_t CFG_TEN_DB     = 3'd4;
    localparam cfg_idx_t CFG_HOLD_TICKS = 3'd5;
    localparam cfg_idx_t CFG_VALUE_RATE = 3'd6;
    localparam cfg_idx_t CFG_PEAK_RATE  = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_SS,
        S_MUL_SSS,
        S_MUL_TGT,
        S_ROOT,
        S_BAR,
        S_MUL_BAR,
        S_MUL_BSQ,
        S_PEAK,
        S_MUL_PK,
        S_MUL_PSQ,
        S_DONE
    } state_t;

endpackage

// ===== sv/peak_hold_level_meter.sv =====
// Peak-hold level meter with accelerating decay.
//
// Level channel: level_valid / level_stall carry one linear amplitude
// (level_in, unsigned Q2.14) per meter tick. The block raises level_stall
// while it works on an item and takes the next one as soon as it is idle.
// Result channel: result_valid / result_stall carry bar_height, peak_height,
// peak_color and changed, one item for every level item, from an output
// register. While the receiver stalls, the block still takes and works on
// the next level item, then waits with that result until the register frees.
// Config channel: cfg_valid / cfg_ready (always ready) writes cfg_data into
// the register at cfg_index; write only while no tick is in flight.
// A quiet tick (below the floor with no peak) goes straight to the done state.
// The time that any other tick takes is set by the shift-and-add multiplier,
// which retires two operand bits a cycle and stops when the operand runs out,
// and, where the tick works out a bar height, by the 13-step cube root
// (3 target bits a cycle). One item is in work at a time.
// Reset: config registers take their defaults, bar and peak are zero, the
// colour zone is the -6 dB zone and both decay factors hold their defaults.
module peak_hold_level_meter
    import plm_pkg::*;
#(
    parameter int LEVEL_BITS      = 16,
    parameter int BAR_BITS        = 13,
    parameter int DECAY_FRAC_BITS = 24
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       level_valid,
    output logic                       level_stall,
    input  logic [LEVEL_BITS-1:0]      level_in,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [BAR_BITS-1:0]        bar_height,
    output logic [BAR_BITS-1:0]        peak_height,
    output logic [ZONE_W-1:0]          peak_color,
    output logic                       changed,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [DECAY_FRAC_BITS-1:0] cfg_data
);

    localparam int DF       = DECAY_FRAC_BITS;
    localparam int LVL_FRAC = LEVEL_BITS - 2;
    localparam int PROD_W   = (3 * SCALE_W + LEVEL_BITS > 2 * DF) ?
                              3 * SCALE_W + LEVEL_BITS : 2 * DF;
    localparam int OPB_W    = (LEVEL_BITS > DF) ? LEVEL_BITS : DF;
    localparam int RW_W     = ROOT_W + BAR_BITS;

    localparam logic [LEVEL_BITS-1:0] FLOOR_LEVEL =
        LEVEL_BITS'((64'd1 << LVL_FRAC) / 64'd1000);
    localparam logic [DF-1:0] VALUE_RATE_RST =
        DF'(((64'd1 << DF) * 64'd99) / 64'd100);
    localparam logic [DF-1:0] PEAK_RATE_RST =
        DF'(((64'd1 << DF) * 64'd999999) / 64'd1000000);
    localparam logic [BAR_BITS-1:0] BAR_MAX = {BAR_BITS{1'b1}};

    state_t state_reg, state_next;

    // Configuration
    logic [SCALE_W-1:0]      scale_reg;
    logic [BAR_BITS-1:0]     zero_db_reg, three_db_reg, six_db_reg, ten_db_reg;
    logic [HOLD_TICKS_W-1:0] hold_ticks_reg;
    logic [DF-1:0]           value_rate_reg, peak_rate_reg;

    // Meter state
    logic [BAR_BITS-1:0] bar_level_reg, bar_level_next;
    logic [BAR_BITS-1:0] peak_level_reg, peak_level_next;
    logic [DF-1:0]       bar_decay_reg, bar_decay_next;
    logic [DF-1:0]       peak_decay_reg, peak_decay_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    zone_t               zone_reg, zone_next;

    // Working registers
    logic [LEVEL_BITS-1:0] level_reg, level_next;
    logic [BAR_BITS-1:0]   val_reg, val_next;
    logic [BAR_BITS-1:0]   pk_reg, pk_next;
    logic [PROD_W-1:0]     mul_a_reg, mul_a_next;
    logic [OPB_W-1:0]      mul_b_reg, mul_b_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [XPAD_W-1:0]     x_reg, x_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [2*ROOT_W-1:0]   root_sq_reg, root_sq_next;
    logic [ROOT_CNT_W-1:0] step_reg, step_next;

    // Result register
    logic                result_valid_reg, result_valid_next;
    logic [BAR_BITS-1:0] bar_height_reg, bar_height_next;
    logic [BAR_BITS-1:0] peak_height_reg, peak_height_next;
    zone_t               peak_color_reg, peak_color_next;
    logic                changed_reg, changed_next;

    // Multiplier step
    logic              mul_busy;
    logic [PROD_W-1:0] pp0, pp1, prod_step, mul_a_step;
    logic [OPB_W-1:0]  mul_b_step;
    logic [BAR_BITS-1:0] prod_hi_bar;
    logic [DF-1:0]       prod_hi_dec;

    // Cube root step
    logic [REM_W-1:0]    r_sh, r_t, r_b;
    logic [ROOT_W-1:0]   y_sh;
    logic [2*ROOT_W-1:0] y2_sh;
    logic                r_ge;
    logic [REM_W-1:0]    rem_step;
    logic [ROOT_W-1:0]   root_step;
    logic [2*ROOT_W-1:0] root_sq_step;
    logic [RW_W-1:0]     root_wide;
    logic [BAR_BITS-1:0] root_sat;

    logic              level_above;
    logic [HOLD_W-1:0] hold_inc;
    zone_t             new_zone;

    assign level_stall  = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign bar_height   = bar_height_reg;
    assign peak_height  = peak_height_reg;
    assign peak_color   = peak_color_reg;
    assign changed      = changed_reg;

    // Two operand bits a cycle
    assign mul_busy    = (mul_b_reg != '0);
    assign pp0         = mul_b_reg[0] ? mul_a_reg : '0;
    assign pp1         = mul_b_reg[1] ? {mul_a_reg[PROD_W-2:0], 1'b0} : '0;
    assign prod_step   = prod_reg + pp0 + pp1;
    assign mul_a_step  = {mul_a_reg[PROD_W-3:0], 2'b00};
    assign mul_b_step  = mul_b_reg >> 2;
    assign prod_hi_bar = BAR_BITS'(prod_reg >> DF);
    assign prod_hi_dec = DF'(prod_reg >> DF);

    // Bring in three target bits, try the next root bit.
    // (y+1)^3 - y^3 = 3(y^2 + y) + 1, with y^2 kept alongside y.
    assign r_sh  = {rem_reg[REM_W-4:0], x_reg[XPAD_W-1 -: 3]};
    assign y_sh  = {root_reg[ROOT_W-2:0], 1'b0};
    assign y2_sh = {root_sq_reg[2*ROOT_W-3:0], 2'b00};
    assign r_t   = REM_W'(y2_sh) + REM_W'(y_sh);
    assign r_b   = r_t + {r_t[REM_W-2:0], 1'b0} + REM_W'(1);
    assign r_ge  = (r_sh >= r_b);

    assign rem_step     = r_ge ? (r_sh - r_b) : r_sh;
    assign root_step    = r_ge ? (y_sh | ROOT_W'(1)) : y_sh;
    assign root_sq_step = r_ge ? (y2_sh + (2*ROOT_W)'({y_sh, 1'b0}) + (2*ROOT_W)'(1))
                               : y2_sh;

    assign root_wide = RW_W'(root_step);
    assign root_sat  = (root_wide > RW_W'(BAR_MAX)) ? BAR_MAX : root_wide[BAR_BITS-1:0];

    assign level_above = (level_in > FLOOR_LEVEL);
    assign hold_inc    = (hold_reg < HOLD_MAX) ? hold_reg + HOLD_W'(1) : hold_reg;

    // Zone walk: step down from -10 dB while the peak reaches that boundary
    always_comb
    begin
        if (val_reg < ten_db_reg)
        begin
            new_zone = ZONE_TEN;
        end
        else if (val_reg < six_db_reg)
        begin
            new_zone = ZONE_SIX;
        end
        else if (val_reg < three_db_reg)
        begin
            new_zone = ZONE_THREE;
        end
        else if (val_reg < zero_db_reg)
        begin
            new_zone = ZONE_ZERO;
        end
        else
        begin
            new_zone = ZONE_OVER;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        bar_level_next    = bar_level_reg;
        peak_level_next   = peak_level_reg;
        bar_decay_next    = bar_decay_reg;
        peak_decay_next   = peak_decay_reg;
        hold_next         = hold_reg;
        zone_next         = zone_reg;
        level_next        = level_reg;
        val_next          = val_reg;
        pk_next           = pk_reg;
        mul_a_next        = mul_a_reg;
        mul_b_next        = mul_b_reg;
        prod_next         = prod_reg;
        x_next            = x_reg;
        rem_next          = rem_reg;
        root_next         = root_reg;
        root_sq_next      = root_sq_reg;
        step_next         = step_reg;
        result_valid_next = result_valid_reg & result_stall;
        bar_height_next   = bar_height_reg;
        peak_height_next  = peak_height_reg;
        peak_color_next   = peak_color_reg;
        changed_next      = changed_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (level_valid)
                begin
                    level_next = level_in;
                    if (level_above)
                    begin
                        mul_a_next = PROD_W'(scale_reg);
                        mul_b_next = OPB_W'(scale_reg);
                        prod_next  = '0;
                        state_next = S_MUL_SS;
                    end
                    else if (peak_level_reg != '0)
                    begin
                        val_next   = '0;
                        state_next = S_BAR;
                    end
                    else
                    begin
                        // quiet tick: report the state unchanged
                        val_next   = bar_level_reg;
                        pk_next    = peak_level_reg;
                        state_next = S_DONE;
                    end
                end
            end

            S_MUL_SS:
            begin
                if (mul_busy)
                begin
                    prod_next  = prod_step;
                    mul_a_next = mul_a_step;
                    mul_b_next = mul_b_step;
                end
                else
                begin
                    mul_a_next = prod_reg;
                    mul_b_next = OPB_W'(scale_reg);
                    prod_next  = '0;
                    state_next = S_MUL_SSS;
                end
            end

            S_MUL_SSS:
            begin
                if (mul_busy)
                begin
                    prod_next  = prod_step;
                    mul_a_next = mul_a_step;
                    mul_b_next = mul_b_step;
                end
                else
                begin
                    mul_a_next = prod_reg;
                    mul_b_next = OPB_W'(level_reg);
                    prod_next  = '0;
                    state_next = S_MUL_TGT;
                end
            end

            S_MUL_TGT:
            begin
                if (mul_busy)
                begin
                    prod_next  = prod_step;
                    mul_a_next = mul_a_step;
                    mul_b_next = mul_b_step;
                end
                else
                begin
                    x_next       = XPAD_W'(prod_reg >> LVL_FRAC);
                    rem_next     = '0;
                    root_next    = '0;
                    root_sq_next = '0;
                    step_next    = ROOT_CNT_W'(ROOT_STEPS - 1);
                    state_next   = S_ROOT;
                end
            end

            S_ROOT:
            begin
                x_next       = {x_reg[XPAD_W-4:0], 3'b000};
                rem_next     = rem_step;
                root_next    = root_step;
                root_sq_next = root_sq_step;
                if (step_reg == '0)
                begin
                    val_next   = root_sat;
                    state_next = S_BAR;
                end
                else
                begin
                    step_next = step_reg - ROOT_CNT_W'(1);
                end
            end

            S_BAR:
            begin
                if (val_reg < bar_level_reg)
                begin
                    mul_a_next = PROD_W'(bar_decay_reg);
                    mul_b_next = OPB_W'(bar_level_reg);
                    prod_next  = '0;
                    state_next = S_MUL_BAR;
                end
                else
                begin
                    bar_decay_next = value_rate_reg;
                    state_next     = S_PEAK;
                end
            end

            S_MUL_BAR:
            begin
                if (mul_busy)
                begin
                    prod_next  = prod_step;
                    mul_a_next = mul_a_step;
                    mul_b_next = mul_b_step;
                end
                else
                begin
                    val_next   = prod_hi_bar;
                    mul_a_next = PROD_W'(bar_decay_reg);
                    mul_b_next = OPB_W'(bar_decay_reg);
                    prod_next  = '0;
                    state_next = S_MUL_BSQ;
                end
            end

            S_MUL_BSQ:
            begin
                if (mul_busy)
                begin
                    prod_next  = prod_step;
                    mul_a_next = mul_a_step;
                    mul_b_next = mul_b_step;
                end
                else
                begin
                    bar_decay_next = prod_hi_dec;
                    state_next     = S_PEAK;
                end
            end

            S_PEAK:
            begin
                if (peak_level_reg < val_reg)
                begin
                    pk_next         = val_reg;
                    hold_next       = '0;
                    peak_decay_next = peak_rate_reg;
                    zone_next       = new_zone;
                    state_next      = S_DONE;
                end
                else
                begin
                    hold_next = hold_inc;
                    pk_next   = peak_level_reg;
                    if (hold_inc > HOLD_W'(hold_ticks_reg))
                    begin
                        mul_a_next = PROD_W'(peak_decay_reg);
                        mul_b_next = OPB_W'(peak_level_reg);
                        prod_next  = '0;
                        state_next = S_MUL_PK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_MUL_PK:
            begin
                if (mul_busy)
                begin
                    prod_next  = prod_step;
                    mul_a_next = mul_a_step;
                    mul_b_next = mul_b_step;
                end
                else if (prod_hi_bar < val_reg)
                begin
                    // never drop the peak below the bar
                    pk_next    = val_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    pk_next    = prod_hi_bar;
                    mul_a_next = PROD_W'(peak_decay_reg);
                    mul_b_next = OPB_W'(peak_decay_reg);
                    prod_next  = '0;
                    state_next = S_MUL_PSQ;
                end
            end

            S_MUL_PSQ:
            begin
                if (mul_busy)
                begin
                    prod_next  = prod_step;
                    mul_a_next = mul_a_step;
                    mul_b_next = mul_b_step;
                end
                else
                begin
                    peak_decay_next = prod_hi_dec;
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold until the result register is free
                if (!result_valid_reg || !result_stall)
                begin
                    bar_height_next   = val_reg;
                    peak_height_next  = pk_reg;
                    peak_color_next   = zone_reg;
                    changed_next      = (val_reg != bar_level_reg) ||
                                        (pk_reg != peak_level_reg);
                    result_valid_next = 1'b1;
                    bar_level_next    = val_reg;
                    peak_level_next   = pk_reg;
                    state_next        = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            bar_level_reg    <= '0;
            peak_level_reg   <= '0;
            bar_decay_reg    <= VALUE_RATE_RST;
            peak_decay_reg   <= PEAK_RATE_RST;
            hold_reg         <= '0;
            zone_reg         <= ZONE_SIX;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            bar_level_reg    <= bar_level_next;
            peak_level_reg   <= peak_level_next;
            bar_decay_reg    <= bar_decay_next;
            peak_decay_reg   <= peak_decay_next;
            hold_reg         <= hold_next;
            zone_reg         <= zone_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= SCALE_W'(204);
            zero_db_reg    <= BAR_BITS'(204);
            three_db_reg   <= BAR_BITS'(189);
            six_db_reg     <= BAR_BITS'(173);
            ten_db_reg     <= BAR_BITS'(153);
            hold_ticks_reg <= HOLD_TICKS_W'(32);
            value_rate_reg <= VALUE_RATE_RST;
            peak_rate_reg  <= PEAK_RATE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SCALE:      scale_reg      <= cfg_data[SCALE_W-1:0];
                CFG_ZERO_DB:    zero_db_reg    <= cfg_data[BAR_BITS-1:0];
                CFG_THREE_DB:   three_db_reg   <= cfg_data[BAR_BITS-1:0];
                CFG_SIX_DB:     six_db_reg     <= cfg_data[BAR_BITS-1:0];
                CFG_TEN_DB:     ten_db_reg     <= cfg_data[BAR_BITS-1:0];
                CFG_HOLD_TICKS: hold_ticks_reg <= cfg_data[HOLD_TICKS_W-1:0];
                CFG_VALUE_RATE: value_rate_reg <= cfg_data;
                CFG_PEAK_RATE:  peak_rate_reg  <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg       <= level_next;
        val_reg         <= val_next;
        pk_reg          <= pk_next;
        mul_a_reg       <= mul_a_next;
        mul_b_reg       <= mul_b_next;
        prod_reg        <= prod_next;
        x_reg           <= x_next;
        rem_reg         <= rem_next;
        root_reg        <= root_next;
        root_sq_reg     <= root_sq_next;
        step_reg        <= step_next;
        bar_height_reg  <= bar_height_next;
        peak_height_reg <= peak_height_next;
        peak_color_reg  <= peak_color_next;
        changed_reg     <= changed_next;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench
    import plm_pkg::*;
;

    localparam int LEVEL_W = 16;
    localparam int BAR_W   = 13;
    localparam int DEC_W   = 24;

    typedef struct packed {
        logic [BAR_W-1:0] bar;
        logic [BAR_W-1:0] peak;
        zone_t            zone;
        logic             chg;
    } reading_t;

    typedef enum int {
        SHAPE_RELEASE,
        SHAPE_STEADY,
        SHAPE_RAMP,
        SHAPE_NOISE,
        SHAPE_FALL
    } shape_t;

    // Meter tracker: mirrors the registers and the meter state, holds the readings still due
    class meter_tracker;
        logic [SCALE_W-1:0]      scale;
        logic [BAR_W-1:0]        zero_db, three_db, six_db, ten_db;
        logic [HOLD_TICKS_W-1:0] hold_ticks;
        logic [DEC_W-1:0]        value_rate, peak_rate;

        logic [BAR_W-1:0]  bar, peak;
        logic [DEC_W-1:0]  bar_decay, peak_decay;
        logic [HOLD_W-1:0] hold;
        zone_t             zone;

        reading_t pending[$];
        int       mismatch_count;
        int       reading_no;

        function new();
            scale      = 12'd204;
            zero_db    = 13'd204;
            three_db   = 13'd189;
            six_db     = 13'd173;
            ten_db     = 13'd153;
            hold_ticks = 8'd32;
            value_rate = 24'd16609443;
            peak_rate  = 24'd16777199;
            bar        = '0;
            peak       = '0;
            bar_decay  = value_rate;
            peak_decay = peak_rate;
            hold       = '0;
            zone       = ZONE_SIX;
            mismatch_count = 0;
            reading_no     = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [DEC_W-1:0] data);
            case (idx)
                CFG_SCALE:      scale      = data[SCALE_W-1:0];
                CFG_ZERO_DB:    zero_db    = data[BAR_W-1:0];
                CFG_THREE_DB:   three_db   = data[BAR_W-1:0];
                CFG_SIX_DB:     six_db     = data[BAR_W-1:0];
                CFG_TEN_DB:     ten_db     = data[BAR_W-1:0];
                CFG_HOLD_TICKS: hold_ticks = data[HOLD_TICKS_W-1:0];
                CFG_VALUE_RATE: value_rate = data;
                CFG_PEAK_RATE:  peak_rate  = data;
                default: ;
            endcase
        endfunction

        function void note_level(logic [LEVEL_W-1:0] level);
            logic [63:0]      s, tgt, c, val, pk;
            logic [BAR_W-1:0] h, bnd;
            logic             above, chg;
            reading_t         r;
            above = 64'(level) * 64'd1000 > 64'(1) << (LEVEL_W - 2);
            chg   = 1'b0;
            if (above || peak != '0)
            begin
                h = '0;
                if (above)
                begin
                    s   = 64'(scale);
                    tgt = (s * s * s * 64'(level)) >> (LEVEL_W - 2);
                    for (int b = BAR_W - 1; b >= 0; b--)
                    begin
                        c = 64'(h) | (64'd1 << b);
                        if (c * c * c <= tgt)
                            h = c[BAR_W-1:0];
                    end
                end
                val = 64'(h);
                if (val < 64'(bar))
                begin
                    val       = (64'(bar_decay) * 64'(bar)) >> DEC_W;
                    bar_decay = DEC_W'((64'(bar_decay) * 64'(bar_decay)) >> DEC_W);
                end
                else
                    bar_decay = value_rate;

                pk = 64'(peak);
                if (pk < val)
                begin
                    // new peak: restart hold, pick the colour zone
                    pk         = val;
                    hold       = '0;
                    peak_decay = peak_rate;
                    zone       = ZONE_TEN;
                    while (zone != ZONE_OVER)
                    begin
                        case (zone)
                            ZONE_ZERO:  bnd = zero_db;
                            ZONE_THREE: bnd = three_db;
                            ZONE_SIX:   bnd = six_db;
                            default:    bnd = ten_db;
                        endcase
                        if (pk < 64'(bnd))
                            break;
                        zone = zone - 1'b1;
                    end
                end
                else
                begin
                    if (hold < HOLD_MAX)
                        hold = hold + 1'b1;
                    if (hold > HOLD_W'(hold_ticks))
                    begin
                        pk = (64'(peak_decay) * pk) >> DEC_W;
                        if (pk < val)
                            pk = val;
                        else
                            peak_decay = DEC_W'((64'(peak_decay) * 64'(peak_decay)) >> DEC_W);
                    end
                end
                chg  = (val != 64'(bar)) || (pk != 64'(peak));
                bar  = val[BAR_W-1:0];
                peak = pk[BAR_W-1:0];
            end
            r.bar  = bar;
            r.peak = peak;
            r.zone = zone;
            r.chg  = chg;
            pending.push_back(r);
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            reading_no++;
            if (pending.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("reading %0d arrived with none due: bar %0d peak %0d zone %0d chg %0d",
                             reading_no, got.bar, got.peak, got.zone, got.chg);
                return;
            end
            want = pending.pop_front();
            if (got.bar != want.bar || got.peak != want.peak || got.zone != want.zone
                || got.chg != want.chg)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("reading %0d mismatch: expected bar %0d peak %0d zone %0d chg %0d, got bar %0d peak %0d zone %0d chg %0d",
                             reading_no, want.bar, want.peak, want.zone, want.chg,
                             got.bar, got.peak, got.zone, got.chg);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 level_valid;
    logic                 level_stall;
    logic [LEVEL_W-1:0]   level_in;
    logic                 result_valid;
    logic                 result_stall;
    logic [BAR_W-1:0]     bar_height;
    logic [BAR_W-1:0]     peak_height;
    logic [ZONE_W-1:0]    peak_color;
    logic                 changed;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DEC_W-1:0]     cfg_data;

    meter_tracker     tracker;
    int               send_idle_pct;
    int               recv_stall_pct;
    logic [DEC_W-1:0] reg_plan[8];

    always #5 clk = ~clk;

    peak_hold_level_meter #(
        .LEVEL_BITS      (LEVEL_W),
        .BAR_BITS        (BAR_W),
        .DECAY_FRAC_BITS (DEC_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .level_valid  (level_valid),
        .level_stall  (level_stall),
        .level_in     (level_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .bar_height   (bar_height),
        .peak_height  (peak_height),
        .peak_color   (peak_color),
        .changed      (changed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic logic [LEVEL_W-1:0] rand_level();
        case ($urandom_range(0, 5))
            0:       return LEVEL_W'($urandom_range(0, 16));
            1:       return LEVEL_W'($urandom_range(17, 40));
            2:       return LEVEL_W'($urandom);
            3:       return LEVEL_W'($urandom_range(49152, 65535));
            4:       return LEVEL_W'($urandom >> $urandom_range(16, 31));
            default: return LEVEL_W'($urandom_range(1000, 20000));
        endcase
    endfunction

    // Pad a register value with junk above its width now and then
    function automatic logic [DEC_W-1:0] with_junk(logic [DEC_W-1:0] value, int width);
        logic [63:0] junk;
        junk = ($urandom_range(0, 1) == 0) ? 64'(0) : (64'($urandom) << width);
        return value | DEC_W'(junk);
    endfunction

    task automatic send_level(input logic [LEVEL_W-1:0] v);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            level_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        level_valid <= 1'b1;
        level_in    <= v;
        do
            @(posedge clk);
        while (!(level_valid && !level_stall));
        tracker.note_level(v);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [DEC_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        tracker.write_reg(idx, data);
    endtask

    task automatic program_registers();
        write_reg(CFG_SCALE,      with_junk(reg_plan[CFG_SCALE], SCALE_W));
        write_reg(CFG_ZERO_DB,    with_junk(reg_plan[CFG_ZERO_DB], BAR_W));
        write_reg(CFG_THREE_DB,   with_junk(reg_plan[CFG_THREE_DB], BAR_W));
        write_reg(CFG_SIX_DB,     with_junk(reg_plan[CFG_SIX_DB], BAR_W));
        write_reg(CFG_TEN_DB,     with_junk(reg_plan[CFG_TEN_DB], BAR_W));
        write_reg(CFG_HOLD_TICKS, with_junk(reg_plan[CFG_HOLD_TICKS], HOLD_TICKS_W));
        write_reg(CFG_VALUE_RATE, reg_plan[CFG_VALUE_RATE]);
        write_reg(CFG_PEAK_RATE,  reg_plan[CFG_PEAK_RATE]);
        cfg_valid <= 1'b0;
    endtask

    task automatic plan_random();
        logic [DEC_W-1:0] s;
        s = ($urandom_range(0, 7) == 0) ? DEC_W'($urandom_range(0, 4095))
                                        : DEC_W'($urandom_range(64, 1024));
        reg_plan[CFG_SCALE] = s;
        if ($urandom_range(0, 3) == 0)
        begin
            reg_plan[CFG_ZERO_DB]  = DEC_W'($urandom_range(0, 8191));
            reg_plan[CFG_THREE_DB] = DEC_W'($urandom_range(0, 8191));
            reg_plan[CFG_SIX_DB]   = DEC_W'($urandom_range(0, 8191));
            reg_plan[CFG_TEN_DB]   = DEC_W'($urandom_range(0, 8191));
        end
        else
        begin
            // zone boundaries roughly where the dB marks fall for this scale
            reg_plan[CFG_ZERO_DB]  = s + DEC_W'($urandom_range(0, 3));
            reg_plan[CFG_THREE_DB] = s * 15 / 16 + DEC_W'($urandom_range(0, 3));
            reg_plan[CFG_SIX_DB]   = s * 27 / 32 + DEC_W'($urandom_range(0, 3));
            reg_plan[CFG_TEN_DB]   = s * 3 / 4 + DEC_W'($urandom_range(0, 3));
        end
        reg_plan[CFG_HOLD_TICKS] = ($urandom_range(0, 3) == 0) ? DEC_W'($urandom_range(0, 255))
                                                               : DEC_W'($urandom_range(0, 40));
        reg_plan[CFG_VALUE_RATE] = ($urandom_range(0, 4) == 0) ? DEC_W'($urandom)
                                   : 24'hFFFFFF - DEC_W'($urandom_range(0, 1 << 20));
        reg_plan[CFG_PEAK_RATE]  = ($urandom_range(0, 4) == 0) ? DEC_W'($urandom)
                                   : 24'hFFFFFF - DEC_W'($urandom_range(0, 1 << 20));
    endtask

    task automatic run_segments(input int count);
        int               sent, len;
        shape_t           shape;
        logic [LEVEL_W-1:0] v;
        sent = 0;
        while (sent < count)
        begin
            shape = shape_t'($urandom_range(SHAPE_RELEASE, SHAPE_FALL));
            len   = $urandom_range(3, 30);
            v     = rand_level();
            for (int j = 0; j < len; j++)
            begin
                send_level(v);
                case (shape)
                    SHAPE_RELEASE: v = LEVEL_W'($urandom_range(0, 16));
                    SHAPE_STEADY:  ;
                    SHAPE_RAMP:    v = (v > 16'd52000) ? v : v + (v >> 2) + 16'd1;
                    SHAPE_NOISE:   v = rand_level();
                    default:       v = v - (v >> 3);
                endcase
            end
            sent += len;
        end
    endtask

    task automatic wait_idle();
        level_valid <= 1'b0;
        while (tracker.pending.size() != 0 || level_stall)
            @(posedge clk);
    endtask

    // Result side: check every accepted reading, stall at random
    initial
    begin
        int       stall_run;
        reading_t got;
        result_stall = 1'b0;
        stall_run    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                got.bar  = bar_height;
                got.peak = peak_height;
                got.zone = peak_color;
                got.chg  = changed;
                tracker.check_reading(got);
            end
            if (stall_run < 40 && $urandom_range(99) < recv_stall_pct)
            begin
                result_stall <= 1'b1;
                stall_run++;
            end
            else
            begin
                result_stall <= 1'b0;
                stall_run = 0;
            end
        end
    end

    initial
    begin
        logic [LEVEL_W-1:0] directed[25];
        logic [LEVEL_W-1:0] steady;
        tracker        = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n       = 1'b0;
        level_valid = 1'b0;
        level_in    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_SCALE;
        cfg_data    = '0;
        directed = '{16'd0, 16'd16, 16'd17, 16'd65535, 16'd65535, 16'd16384, 16'd0, 16'd0,
                     16'd0, 16'd0, 16'd8192, 16'd21845, 16'd43690, 16'd1, 16'd17, 16'd0,
                     16'd32768, 16'd65535, 16'd4096, 16'd0, 16'd0, 16'd0, 16'd255,
                     16'd65280, 16'd0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values first: quiet ticks, floor edge, full scale, release
        foreach (directed[i])
            send_level(directed[i]);
        wait_idle();

        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            case (phase)
                0:
                begin
                    reg_plan[CFG_SCALE]      = 24'd4095;
                    reg_plan[CFG_ZERO_DB]    = 24'd8191;
                    reg_plan[CFG_THREE_DB]   = 24'd8191;
                    reg_plan[CFG_SIX_DB]     = 24'd8191;
                    reg_plan[CFG_TEN_DB]     = 24'd8191;
                    reg_plan[CFG_HOLD_TICKS] = 24'd255;
                    reg_plan[CFG_VALUE_RATE] = 24'hFFFFFF;
                    reg_plan[CFG_PEAK_RATE]  = 24'hFFFFFF;
                end
                1:
                    foreach (reg_plan[k])
                        reg_plan[k] = '0;
                2:
                begin
                    // zero decay: bar and peak drop at once
                    foreach (reg_plan[k])
                        reg_plan[k] = '0;
                    reg_plan[CFG_SCALE] = DEC_W'($urandom_range(100, 900));
                end
                3:
                begin
                    reg_plan[CFG_SCALE]      = 24'd204;
                    reg_plan[CFG_ZERO_DB]    = 24'd204;
                    reg_plan[CFG_THREE_DB]   = 24'd189;
                    reg_plan[CFG_SIX_DB]     = 24'd173;
                    reg_plan[CFG_TEN_DB]     = 24'd153;
                    reg_plan[CFG_HOLD_TICKS] = 24'd32;
                    reg_plan[CFG_VALUE_RATE] = 24'd16609443;
                    reg_plan[CFG_PEAK_RATE]  = 24'd16777199;
                end
                4:
                begin
                    plan_random();
                    reg_plan[CFG_HOLD_TICKS] = 24'd255;
                end
                default:
                    plan_random();
            endcase
            program_registers();
            if (phase == 4)
            begin
                // hold one level long enough for the hold counter to saturate
                steady = LEVEL_W'($urandom_range(17, 65535));
                repeat (520) send_level(steady);
            end
            else
                run_segments((phase < 3) ? 60 : (phase == 3) ? 100 : 80);
            wait_idle();
        end

        repeat (100) @(posedge clk);
        if (tracker.pending.size() != 0)
        begin
            tracker.mismatch_count++;
            $display("%0d readings still due at the end", tracker.pending.size());
        end
        if (tracker.mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/plm_pkg.sv
sv/peak_hold_level_meter.sv
tb/sv/testbench.sv
